FILE: hdl/one_wire_bus_master_unit_macros.svh
// assertion macros used by the bus master sequencer rtl
`ifndef ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define OWBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/owbm_pkg.sv
// types, codes and constants of the 1-wire bus master
package owbm_pkg;

  // default counter width and signed width for timing sums
  localparam int COUNTER_BITS_DEF = 11;
  localparam int SUM_W            = 13;

  // configuration register reset values
  localparam logic [9:0] SLOT_TIME_RST        = 10'd60;
  localparam logic [7:0] RECOVERY_TIME_RST    = 8'd10;
  localparam logic [5:0] INIT_LOW_TIME_RST    = 6'd2;
  localparam logic [5:0] READ_SAMPLE_TIME_RST = 6'd15;
  localparam logic [9:0] RESET_LOW_TIME_RST   = 10'd480;
  localparam logic [9:0] RESET_HIGH_TIME_RST  = 10'd480;
  localparam logic [9:0] PRS_SAMPLE_TIME_RST  = 10'd70;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TIME        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOW_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HIGH_TIME  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRS_SAMPLE_TIME  = 3'd6;

  // command codes
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_RST_PRS  = 4'd1;
  localparam logic [3:0] CMD_RST      = 4'd2;
  localparam logic [3:0] CMD_PRS      = 4'd3;
  localparam logic [3:0] CMD_WR_BIT   = 4'd4;
  localparam logic [3:0] CMD_RD_BIT   = 4'd5;
  localparam logic [3:0] CMD_WR_BYTE  = 4'd6;
  localparam logic [3:0] CMD_RD_BYTE  = 4'd7;
  localparam logic [3:0] CMD_RD_2BITS = 4'd8;

  // sequencer phases
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_RST_LOW   = 8'b0000_0010,
    PH_PRS_WAIT  = 8'b0000_0100,
    PH_PRS_TAIL  = 8'b0000_1000,
    PH_SLOT_LOW  = 8'b0001_0000,
    PH_SLOT_HIGH = 8'b0010_0000,
    PH_RD_WAIT   = 8'b0100_0000,
    PH_RD_TAIL   = 8'b1000_0000
  } phase_t;

  // one tick beat
  typedef struct packed {
    logic [3:0] command;
    logic [7:0] data_in;
    logic       line_level;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;
  } out_item_t;

  // timing registers
  typedef struct packed {
    logic [9:0] slot_time;
    logic [7:0] recovery_time;
    logic [5:0] init_low_time;
    logic [5:0] read_sample_time;
    logic [9:0] reset_low_time;
    logic [9:0] reset_high_time;
    logic [9:0] presence_sample_time;
  } cfg_regs_t;

endpackage

FILE: hdl/owbm_seq.sv
// bus sequencer: phase state, slot timing and the per-tick result
`include "one_wire_bus_master_unit_macros.svh"

module owbm_seq import owbm_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  cfg_regs_t cfg_i,
  output out_item_t res_o
);

  localparam int CMP_W = ((COUNTER_BITS > SUM_W) ? COUNTER_BITS : SUM_W) + 1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // state registers
  phase_t     phase_r, phase_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [3:0] bl_r, bl_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] ac_r, ac_nxt;
  logic       pf_r, pf_nxt;

  // clamp a signed interval into the counter range
  function automatic cnt_t sat_cnt(input sum_t v);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] lim;
    cnt_t             res;
    ext = {{(CMP_W-SUM_W){1'b0}}, v};
    lim = CMP_W'({COUNTER_BITS{1'b1}});
    if (v < 0) begin
      res = '0;
    end else if (ext > lim) begin
      res = '1;
    end else begin
      res = ext[COUNTER_BITS-1:0];
    end
    return res;
  endfunction

  // a zero interval still lasts one tick
  function automatic cnt_t min1(input cnt_t d);
    return (d == '0) ? cnt_t'(1) : d;
  endfunction

  // interval lengths from the timing registers
  sum_t slot_s, rec_s, init_s, rd_s, rlow_s, rhigh_s, prs_s;
  cnt_t d_rst_low, d_prs, d_init, d_slot, d_rd;
  cnt_t tail_prs, tail_w1, tail_w0, tail_rd;

  assign slot_s  = signed'(SUM_W'(cfg_i.slot_time));
  assign rec_s   = signed'(SUM_W'(cfg_i.recovery_time));
  assign init_s  = signed'(SUM_W'(cfg_i.init_low_time));
  assign rd_s    = signed'(SUM_W'(cfg_i.read_sample_time));
  assign rlow_s  = signed'(SUM_W'(cfg_i.reset_low_time));
  assign rhigh_s = signed'(SUM_W'(cfg_i.reset_high_time));
  assign prs_s   = signed'(SUM_W'(cfg_i.presence_sample_time));

  assign d_rst_low = min1(sat_cnt(rlow_s));
  assign d_prs     = min1(sat_cnt(prs_s));
  assign d_init    = min1(sat_cnt(init_s));
  assign d_slot    = min1(sat_cnt(slot_s));
  assign d_rd      = min1(sat_cnt(rd_s));
  assign tail_prs  = sat_cnt(rhigh_s - prs_s);
  assign tail_w1   = sat_cnt(slot_s + rec_s - init_s);
  assign tail_w0   = sat_cnt(rec_s);
  assign tail_rd   = sat_cnt(slot_s + rec_s - init_s - rd_s);

  // one tick: optional start, count down, phase change on expiry
  always_comb begin
    phase_t     ph;
    cnt_t       cnt;
    cnt_t       tail;
    logic [3:0] bl;
    logic [7:0] sh;
    logic [3:0] ac;
    logic       pf;
    logic       valid_cmd;
    logic       is_wr;
    logic       end_slot;
    logic       fin;
    logic [2:0] pos;
    ph        = phase_r;
    cnt       = cnt_r;
    bl        = bl_r;
    sh        = sh_r;
    ac        = ac_r;
    pf        = pf_r;
    tail      = '0;
    end_slot  = 1'b0;
    fin       = 1'b0;
    pos       = '0;
    res_o     = '0;
    valid_cmd = (item_i.command >= CMD_RST_PRS) && (item_i.command <= CMD_RD_2BITS);

    // start a sequence or flag a busy collision
    if (ph == PH_IDLE) begin
      if (valid_cmd) begin
        ac = item_i.command;
        sh = '0;
        bl = '0;
        unique case (item_i.command)
          CMD_RST_PRS, CMD_RST: begin
            ph  = PH_RST_LOW;
            cnt = d_rst_low;
          end
          CMD_PRS: begin
            ph  = PH_PRS_WAIT;
            cnt = d_prs;
          end
          CMD_WR_BIT: begin
            sh  = {7'b0, item_i.data_in[0]};
            bl  = 4'd1;
            ph  = PH_SLOT_LOW;
            cnt = sh[0] ? d_init : d_slot;
          end
          CMD_RD_BIT: begin
            bl  = 4'd1;
            ph  = PH_SLOT_LOW;
            cnt = d_init;
          end
          CMD_WR_BYTE: begin
            sh  = item_i.data_in;
            bl  = 4'd8;
            ph  = PH_SLOT_LOW;
            cnt = sh[0] ? d_init : d_slot;
          end
          CMD_RD_BYTE: begin
            bl  = 4'd8;
            ph  = PH_SLOT_LOW;
            cnt = d_init;
          end
          default: begin
            // read two bits
            bl  = 4'd2;
            ph  = PH_SLOT_LOW;
            cnt = d_init;
          end
        endcase
      end
    end else if (valid_cmd) begin
      res_o.rejected = 1'b1;
    end

    is_wr = (ac == CMD_WR_BIT) || (ac == CMD_WR_BYTE);

    // active tick
    if (ph != PH_IDLE) begin
      res_o.busy_res  = 1'b1;
      res_o.drive_low = (ph == PH_RST_LOW) || (ph == PH_SLOT_LOW);
      if (cnt != '0) begin
        cnt = cnt - cnt_t'(1);
      end
      if (cnt == '0) begin
        unique case (ph)
          PH_RST_LOW: begin
            if (ac == CMD_RST) begin
              fin = 1'b1;
            end else begin
              ph  = PH_PRS_WAIT;
              cnt = d_prs;
            end
          end
          PH_PRS_WAIT: begin
            pf = ~item_i.line_level;
            if (tail_prs != '0) begin
              ph  = PH_PRS_TAIL;
              cnt = tail_prs;
            end else begin
              fin = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (is_wr) begin
              tail = sh[0] ? tail_w1 : tail_w0;
              if (tail != '0) begin
                ph  = PH_SLOT_HIGH;
                cnt = tail;
              end else begin
                end_slot = 1'b1;
              end
            end else begin
              ph  = PH_RD_WAIT;
              cnt = d_rd;
            end
          end
          PH_RD_WAIT: begin
            // store the sampled bit
            if (ac == CMD_RD_BYTE) begin
              sh = {item_i.line_level, sh[7:1]};
            end else if (ac == CMD_RD_2BITS) begin
              pos = 3'd2 - {1'b0, bl[1:0]};
              sh  = sh | (8'(item_i.line_level) << pos);
            end else begin
              sh = {7'b0, item_i.line_level};
            end
            if (tail_rd != '0) begin
              ph  = PH_RD_TAIL;
              cnt = tail_rd;
            end else begin
              end_slot = 1'b1;
            end
          end
          PH_SLOT_HIGH, PH_RD_TAIL: begin
            end_slot = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        // slot done: next bit or finish
        if (end_slot) begin
          if (is_wr) begin
            sh = sh >> 1;
          end
          if (bl != '0) begin
            bl = bl - 4'd1;
          end
          if (bl != '0) begin
            ph  = PH_SLOT_LOW;
            cnt = (is_wr && !sh[0]) ? d_slot : d_init;
          end else begin
            fin = 1'b1;
          end
        end

        // sequence complete
        if (fin) begin
          ph             = PH_IDLE;
          cnt            = '0;
          res_o.done_res = 1'b1;
          if ((ac == CMD_RD_BIT) || (ac == CMD_RD_BYTE) || (ac == CMD_RD_2BITS)) begin
            res_o.read_data = sh;
          end
        end
      end
    end

    res_o.presence = pf;
    phase_nxt      = ph;
    cnt_nxt        = cnt;
    bl_nxt         = bl;
    sh_nxt         = sh;
    ac_nxt         = ac;
    pf_nxt         = pf;
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bl_r    <= '0;
      sh_r    <= '0;
      ac_r    <= CMD_NONE;
      pf_r    <= 1'b0;
    end else if (adv_i) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bl_r    <= bl_nxt;
      sh_r    <= sh_nxt;
      ac_r    <= ac_nxt;
      pf_r    <= pf_nxt;
    end
  end

  // checks
  `OWBM_ASSERT_NOW(a_idle_cnt_zero, phase_r == PH_IDLE, cnt_r == '0, "idle with live counter")
  `OWBM_ASSERT_NOW(a_reject_busy, res_o.rejected, phase_r != PH_IDLE, "reject while idle")
  `OWBM_ASSERT_NOW(a_data_on_done, res_o.read_data != 8'd0, res_o.done_res, "read data w/o done")
  `OWBM_ASSERT_NEXT(a_done_to_idle, adv_i && res_o.done_res, phase_r == PH_IDLE, "done not idle")

endmodule

FILE: hdl/one_wire_bus_master_unit.sv
// 1-wire bus master top level: timing registers, sequencer and result register
//
// Each input beat is one microsecond tick carrying an optional command, a data
// byte and the sampled bus level; each accepted tick yields exactly one result
// beat with the line drive, busy/done flags, read data, presence and a reject
// flag. The block takes one tick per clock: the sequencer evaluates a tick
// combinationally and the result is held in an output register, so a new tick
// is accepted whenever that register is empty or being taken in the same
// cycle (in_stall follows out_stall only while a result is waiting). Timing
// registers are written through the cfg port, which is always ready; write
// them only while no sequence is running.

module one_wire_bus_master_unit import owbm_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg_r;
  out_item_t res;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      adv;

  // handshake
  assign in_stall  = out_valid_r & out_stall;
  assign adv       = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_time            <= SLOT_TIME_RST;
      cfg_r.recovery_time        <= RECOVERY_TIME_RST;
      cfg_r.init_low_time        <= INIT_LOW_TIME_RST;
      cfg_r.read_sample_time     <= READ_SAMPLE_TIME_RST;
      cfg_r.reset_low_time       <= RESET_LOW_TIME_RST;
      cfg_r.reset_high_time      <= RESET_HIGH_TIME_RST;
      cfg_r.presence_sample_time <= PRS_SAMPLE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOT_TIME:        cfg_r.slot_time            <= cfg_data;
        CFG_RECOVERY_TIME:    cfg_r.recovery_time        <= cfg_data[7:0];
        CFG_INIT_LOW_TIME:    cfg_r.init_low_time        <= cfg_data[5:0];
        CFG_READ_SAMPLE_TIME: cfg_r.read_sample_time     <= cfg_data[5:0];
        CFG_RESET_LOW_TIME:   cfg_r.reset_low_time       <= cfg_data;
        CFG_RESET_HIGH_TIME:  cfg_r.reset_high_time      <= cfg_data;
        CFG_PRS_SAMPLE_TIME:  cfg_r.presence_sample_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick sequencer
  owbm_seq #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .item_i (in_data),
    .cfg_i  (cfg_r),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: tb/one_wire_bus_master_unit_tb.sv
// self-checking testbench for the 1-wire bus master: tick beats in, predicted result beats out
module one_wire_bus_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  localparam int TICK_LIMIT  = (1 << COUNTER_BITS_DEF) - 1;
  localparam int HOLD_CYCLES = 200;
  localparam int SHOW_MAX    = 40;

  // line level choices for a command run
  localparam int LVL_LOW  = 0;
  localparam int LVL_HIGH = 1;
  localparam int LVL_RAND = 2;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // sequencer model state and timing registers
  phase_t      seq_ph;
  int unsigned seq_ticks;
  int unsigned seq_bits;
  logic [7:0]  seq_shift;
  logic [3:0]  seq_cmd;
  logic        seq_presence;
  logic        seq_done;
  logic [7:0]  seq_rdata;
  cfg_regs_t   timing;

  out_item_t   expected_beats[$];
  int          err_cnt;
  bit          quiet;
  bit          hold_req;

  one_wire_bus_master_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sequencer model
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_ticks(int v);
    if (v < 0) return 0;
    if (v > TICK_LIMIT) return TICK_LIMIT;
    return v;
  endfunction

  function automatic void enter_phase(phase_t p, int unsigned d);
    seq_ph    = p;
    seq_ticks = d;
  endfunction

  // zero-length low or wait intervals still take one tick
  function automatic void enter_phase_min1(phase_t p, int v);
    int unsigned d;
    d = clamp_ticks(v);
    enter_phase(p, (d == 0) ? 1 : d);
  endfunction

  function automatic bit cmd_is_write();
    return (seq_cmd == CMD_WR_BIT) || (seq_cmd == CMD_WR_BYTE);
  endfunction

  function automatic void end_sequence();
    seq_ph    = PH_IDLE;
    seq_ticks = 0;
    seq_done  = 1'b1;
    if (seq_cmd == CMD_RD_BIT || seq_cmd == CMD_RD_BYTE || seq_cmd == CMD_RD_2BITS)
      seq_rdata = seq_shift;
  endfunction

  function automatic void open_slot();
    if (cmd_is_write())
      enter_phase_min1(PH_SLOT_LOW, seq_shift[0] ? int'(timing.init_low_time)
                                                 : int'(timing.slot_time));
    else
      enter_phase_min1(PH_SLOT_LOW, int'(timing.init_low_time));
  endfunction

  function automatic void close_slot();
    if (cmd_is_write()) seq_shift = seq_shift >> 1;
    if (seq_bits > 0) seq_bits--;
    if (seq_bits > 0) open_slot();
    else end_sequence();
  endfunction

  // read bytes shift in from the top, read2bits fills bit 0 then bit 1
  function automatic void capture_bit(logic b);
    int pos;
    if (seq_cmd == CMD_RD_BYTE) begin
      seq_shift = {b, seq_shift[7:1]};
    end else if (seq_cmd == CMD_RD_2BITS) begin
      pos = (2 - int'(seq_bits % 4)) & 7;
      seq_shift = seq_shift | (8'(b) << pos);
    end else begin
      seq_shift = {7'd0, b};
    end
  endfunction

  // phase change on the last tick of an interval
  function automatic void step_phase(logic lvl);
    int unsigned tail;
    case (seq_ph)
      PH_RST_LOW: begin
        if (seq_cmd == CMD_RST) end_sequence();
        else enter_phase_min1(PH_PRS_WAIT, int'(timing.presence_sample_time));
      end
      PH_PRS_WAIT: begin
        seq_presence = ~lvl;
        tail = clamp_ticks(int'(timing.reset_high_time) - int'(timing.presence_sample_time));
        if (tail > 0) enter_phase(PH_PRS_TAIL, tail);
        else end_sequence();
      end
      PH_SLOT_LOW: begin
        if (cmd_is_write()) begin
          if (seq_shift[0])
            tail = clamp_ticks(int'(timing.slot_time) + int'(timing.recovery_time)
                               - int'(timing.init_low_time));
          else
            tail = clamp_ticks(int'(timing.recovery_time));
          if (tail > 0) enter_phase(PH_SLOT_HIGH, tail);
          else close_slot();
        end else begin
          enter_phase_min1(PH_RD_WAIT, int'(timing.read_sample_time));
        end
      end
      PH_RD_WAIT: begin
        capture_bit(lvl);
        tail = clamp_ticks(int'(timing.slot_time) + int'(timing.recovery_time)
                           - int'(timing.init_low_time) - int'(timing.read_sample_time));
        if (tail > 0) enter_phase(PH_RD_TAIL, tail);
        else close_slot();
      end
      PH_SLOT_HIGH, PH_RD_TAIL: begin
        close_slot();
      end
      default: begin
        end_sequence();
      end
    endcase
  endfunction

  function automatic void start_sequence(logic [3:0] cmd, logic [7:0] data);
    seq_cmd   = cmd;
    seq_shift = '0;
    seq_bits  = 0;
    case (cmd)
      CMD_RST_PRS, CMD_RST: enter_phase_min1(PH_RST_LOW, int'(timing.reset_low_time));
      CMD_PRS: enter_phase_min1(PH_PRS_WAIT, int'(timing.presence_sample_time));
      CMD_WR_BIT: begin
        seq_shift = {7'd0, data[0]};
        seq_bits  = 1;
        open_slot();
      end
      CMD_RD_BIT: begin
        seq_bits = 1;
        open_slot();
      end
      CMD_WR_BYTE: begin
        seq_shift = data;
        seq_bits  = 8;
        open_slot();
      end
      CMD_RD_BYTE: begin
        seq_bits = 8;
        open_slot();
      end
      default: begin
        seq_bits = 2;
        open_slot();
      end
    endcase
  endfunction

  // result beat for one tick beat
  function automatic out_item_t predict_beat(in_item_t t);
    out_item_t r;
    bit        known;
    known     = (t.command >= CMD_RST_PRS) && (t.command <= CMD_RD_2BITS);
    r         = '0;
    seq_done  = 1'b0;
    seq_rdata = '0;
    if (seq_ph == PH_IDLE) begin
      if (known) start_sequence(t.command, t.data_in);
    end else if (known) begin
      r.rejected = 1'b1;
    end
    if (seq_ph != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (seq_ph == PH_RST_LOW) || (seq_ph == PH_SLOT_LOW);
      if (seq_ticks > 0) seq_ticks--;
      if (seq_ticks == 0) step_phase(t.line_level);
    end
    r.done_res  = seq_done;
    r.read_data = seq_rdata;
    r.presence  = seq_presence;
    return r;
  endfunction

  function automatic void reset_model();
    timing.slot_time            = SLOT_TIME_RST;
    timing.recovery_time        = RECOVERY_TIME_RST;
    timing.init_low_time        = INIT_LOW_TIME_RST;
    timing.read_sample_time     = READ_SAMPLE_TIME_RST;
    timing.reset_low_time       = RESET_LOW_TIME_RST;
    timing.reset_high_time      = RESET_HIGH_TIME_RST;
    timing.presence_sample_time = PRS_SAMPLE_TIME_RST;
    seq_ph       = PH_IDLE;
    seq_ticks    = 0;
    seq_bits     = 0;
    seq_shift    = '0;
    seq_cmd      = CMD_NONE;
    seq_presence = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic logic level_of(int lvl);
    return (lvl == LVL_RAND) ? 1'($urandom_range(0, 1)) : 1'(lvl);
  endfunction

  // one tick beat; valid stays high unless a random gap follows
  task automatic send_tick(in_item_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_beat(t));
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // command beat, then filler ticks until the sequence is over
  task automatic run_command(logic [3:0] cmd, logic [7:0] data, int lvl, int noise_pct);
    in_item_t t;
    t.command    = cmd;
    t.data_in    = data;
    t.line_level = level_of(lvl);
    send_tick(t);
    while (seq_ph != PH_IDLE) begin
      t.command    = ($urandom_range(0, 99) < noise_pct) ? 4'($urandom_range(1, 15))
                                                         : CMD_NONE;
      t.data_in    = 8'($urandom);
      t.line_level = level_of(lvl);
      send_tick(t);
    end
  endtask

  // stop sending and wait for every outstanding result beat
  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SLOT_TIME:        timing.slot_time            = val;
      CFG_RECOVERY_TIME:    timing.recovery_time        = val[7:0];
      CFG_INIT_LOW_TIME:    timing.init_low_time        = val[5:0];
      CFG_READ_SAMPLE_TIME: timing.read_sample_time     = val[5:0];
      CFG_RESET_LOW_TIME:   timing.reset_low_time       = val;
      CFG_RESET_HIGH_TIME:  timing.reset_high_time      = val;
      CFG_PRS_SAMPLE_TIME:  timing.presence_sample_time = val;
      default: ;
    endcase
  endtask

  // full timing set, written only with the sequencer idle
  task automatic apply_timing(cfg_regs_t c);
    drain_ticks();
    write_reg(CFG_SLOT_TIME,        CFG_DATA_W'(c.slot_time));
    write_reg(CFG_RECOVERY_TIME,    CFG_DATA_W'(c.recovery_time));
    write_reg(CFG_INIT_LOW_TIME,    CFG_DATA_W'(c.init_low_time));
    write_reg(CFG_READ_SAMPLE_TIME, CFG_DATA_W'(c.read_sample_time));
    write_reg(CFG_RESET_LOW_TIME,   CFG_DATA_W'(c.reset_low_time));
    write_reg(CFG_RESET_HIGH_TIME,  CFG_DATA_W'(c.reset_high_time));
    write_reg(CFG_PRS_SAMPLE_TIME,  CFG_DATA_W'(c.presence_sample_time));
    cfg_valid <= 1'b0;
  endtask

  // short timings keep random sequences brief, zero included
  function automatic cfg_regs_t rand_timing();
    cfg_regs_t c;
    c.slot_time            = 10'($urandom_range(0, 6));
    c.recovery_time        = 8'($urandom_range(0, 3));
    c.init_low_time        = 6'($urandom_range(0, 3));
    c.read_sample_time     = 6'($urandom_range(0, 3));
    c.reset_low_time       = 10'($urandom_range(0, 6));
    c.reset_high_time      = 10'($urandom_range(0, 8));
    c.presence_sample_time = 10'($urandom_range(0, 8));
    return c;
  endfunction

  function automatic logic [3:0] rand_cmd();
    logic [3:0] cmd;
    cmd = 4'($urandom_range(CMD_RST_PRS, CMD_RD_2BITS));
    // occasional idle or unknown code in place of a command
    if ($urandom_range(0, 9) == 0) cmd = 4'($urandom_range(0, 15));
    return cmd;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // slot timings as left by reset
  task automatic test_reset_timing();
    run_command(CMD_RD_BIT, 8'h00, LVL_RAND, 0);
  endtask

  // every command and two unknown codes with short timings
  task automatic test_each_command();
    apply_timing('{10'd2, 8'd1, 6'd1, 6'd1, 10'd3, 10'd4, 10'd2});
    run_command(CMD_RST_PRS, 8'h00, LVL_HIGH, 0);
    run_command(CMD_RST, 8'hFF, LVL_RAND, 0);
    run_command(CMD_PRS, 8'h00, LVL_LOW, 0);
    run_command(CMD_WR_BIT, 8'h01, LVL_RAND, 0);
    run_command(CMD_WR_BIT, 8'hFE, LVL_RAND, 0);
    run_command(CMD_RD_BIT, 8'h00, LVL_HIGH, 0);
    run_command(CMD_WR_BYTE, 8'h5A, LVL_RAND, 0);
    run_command(CMD_RD_BYTE, 8'hFF, LVL_RAND, 0);
    run_command(CMD_RD_2BITS, 8'h00, LVL_RAND, 0);
    run_command(4'hF, 8'hFF, LVL_RAND, 0);
    run_command(4'h9, 8'h00, LVL_RAND, 0);
  endtask

  // commands and unknown codes arriving mid-sequence
  task automatic test_busy_reject();
    run_command(CMD_WR_BYTE, 8'hA5, LVL_RAND, 50);
  endtask

  // tails that come out negative are skipped
  task automatic test_negative_tail();
    apply_timing('{10'd2, 8'd1, 6'd5, 6'd7, 10'd3, 10'd2, 10'd9});
    run_command(CMD_RD_BIT, 8'h00, LVL_LOW, 0);
    run_command(CMD_WR_BIT, 8'h01, LVL_RAND, 0);
    run_command(CMD_WR_BIT, 8'h00, LVL_RAND, 0);
    run_command(CMD_RST_PRS, 8'h00, LVL_LOW, 0);
    run_command(CMD_PRS, 8'h00, LVL_HIGH, 0);
  endtask

  // zero-length low and wait intervals take one tick
  task automatic test_zero_timing();
    apply_timing('0);
    run_command(CMD_RST_PRS, 8'h00, LVL_LOW, 0);
    run_command(CMD_WR_BYTE, 8'h3C, LVL_RAND, 0);
    run_command(CMD_RD_2BITS, 8'h00, LVL_RAND, 0);
    run_command(CMD_RD_BYTE, 8'h00, LVL_RAND, 0);
  endtask

  // init low pulse at the top of its range, high time clamped away
  task automatic test_max_timing();
    apply_timing('{10'd1, 8'd1, 6'd63, 6'd63, 10'd1, 10'd1, 10'd1});
    run_command(CMD_WR_BIT, 8'h01, LVL_RAND, 0);
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_hold();
    apply_timing('{10'd1, 8'd1, 6'd1, 6'd1, 10'd1, 10'd1, 10'd1});
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) run_command(rand_cmd(), 8'($urandom), LVL_RAND, 5);
  endtask

  // sender waits until every result beat is back, then carries on
  task automatic test_sender_pause();
    for (int k = 0; k < 3; k++) run_command(rand_cmd(), 8'($urandom), LVL_RAND, 5);
    drain_ticks();
    for (int k = 0; k < 3; k++) run_command(rand_cmd(), 8'($urandom), LVL_RAND, 5);
  endtask

  // random timings and commands, no idling in the last phase
  task automatic test_random_traffic();
    for (int p = 0; p < 3; p++) begin
      apply_timing(rand_timing());
      if (p == 2) quiet = 1'b1;
      for (int k = 0; k < 3; k++) run_command(rand_cmd(), 8'($urandom), LVL_RAND, 5);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls: random bursts plus the requested long hold-off
  initial begin : out_stall_drive
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= SHOW_MAX)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // compare each accepted result beat with the oldest prediction
  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t ns: result beat with none expected, expected none actual %h",
                     $time, out_data);
        end else begin
          want = expected_beats.pop_front();
          check_field("drive_low", 8'(want.drive_low), 8'(out_data.drive_low));
          check_field("busy_res",  8'(want.busy_res),  8'(out_data.busy_res));
          check_field("done_res",  8'(want.done_res),  8'(out_data.done_res));
          check_field("read_data", want.read_data,     out_data.read_data);
          check_field("presence",  8'(want.presence),  8'(out_data.presence));
          check_field("rejected",  8'(want.rejected),  8'(out_data.rejected));
        end
      end
    end
  end

  // run limit
  initial begin
    #60_000_000;
    $display("one_wire_bus_master_unit_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    err_cnt   = 0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_timing();
    test_each_command();
    test_busy_reject();
    test_negative_tail();
    test_zero_timing();
    test_max_timing();
    test_output_hold();
    test_sender_pause();
    test_random_traffic();

    drain_ticks();
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("one_wire_bus_master_unit_tb OK");
    end else begin
      $display("one_wire_bus_master_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/owbm_pkg.sv
hdl/owbm_seq.sv
hdl/one_wire_bus_master_unit.sv
tb/one_wire_bus_master_unit_tb.sv
